>>> design/itbd_pkg.sv
// Package with the shared widths, command and status types and the digit-to-character function.
package itbd_pkg;

    localparam int VALUE_W      = 64;
    localparam int BASE_W       = 5;
    localparam int CHAR_W       = 7;
    localparam int DIGIT_W      = 4;
    localparam int STACK_DEPTH  = 64;
    localparam int PTR_W        = 6;
    localparam int SP_W         = 7;
    localparam int DIV_BITS     = 8;
    localparam int STEP_CNT_W   = 3;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_2   = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_4   = BASE_W'(4);
    localparam logic [BASE_W-1:0] BASE_8   = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_16  = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        logic shift_step;
        logic err_push;
        logic emit;
    } itbd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_base;
        logic pow2;
        logic quo_zero;
        logic emit_done;
    } itbd_status_t;

    // Maps a digit value to its lowercase ASCII character.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10))
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return c;
    endfunction

endpackage

>>> design/itbd_in_if.sv
// Input channel interface: value and base with a valid/ready handshake.
interface itbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [itbd_pkg::VALUE_W-1:0] value;
    logic [itbd_pkg::BASE_W-1:0]  base;

    modport source (output valid, output value, output base, input ready);
    modport sink (input valid, input value, input base, output ready);
endinterface

>>> design/itbd_out_if.sv
// Output channel interface: one digit word with flags and a valid/ready handshake.
interface itbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [itbd_pkg::CHAR_W-1:0] digit_char;
    logic                        is_negative;
    logic                        last;
    logic                        base_error;

    modport source (output valid, output digit_char, output is_negative, output last,
                    output base_error, input ready);
    modport sink (input valid, input digit_char, input is_negative, input last,
                  input base_error, output ready);
endinterface

>>> design/int_to_base_digits_unit.sv
// Top level of the signed 64-bit to base 2..16 ASCII digit converter.
// Sequence: accept, then one shift step per digit for bases 2, 4, 8 and 16, or a full
// 64-bit restoring division per digit for other bases (divider retires 8 quotient bits per
// cycle), then each digit pops from the stack via the stack read register to the output.
// A new item is accepted only once the stack and its read register hold no digits.
// Reset is asynchronous, active low; it clears the controller, stack pointer and valids.
module int_to_base_digits_unit (
    input  logic      clk,
    input  logic      rst_n,
    itbd_in_if.sink   in_chan,
    itbd_out_if.source out_chan
);
    import itbd_pkg::*;

    itbd_cmd_t    cmd;
    itbd_status_t status;

    // Sequencer.
    itbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_ready (in_chan.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Conversion datapath and output stage.
    itbd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_value        (in_chan.value),
        .in_base         (in_chan.base),
        .out_valid       (out_chan.valid),
        .out_ready       (out_chan.ready),
        .out_digit_char  (out_chan.digit_char),
        .out_is_negative (out_chan.is_negative),
        .out_last        (out_chan.last),
        .out_base_error  (out_chan.base_error)
    );

endmodule

>>> design/itbd_ctrl.sv
// Controller state machine that sequences conversion and digit emission.
module itbd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  itbd_pkg::itbd_status_t status,
    output itbd_pkg::itbd_cmd_t    cmd
);
    import itbd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_ERR   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [STEP_CNT_W-1:0] STEP_LAST = {STEP_CNT_W{1'b1}};

    logic [2:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic                  accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state, step counter and commands.
    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (status.bad_base)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (status.pow2)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_last  = (step_cnt_reg == STEP_LAST);
                step_cnt_next = step_cnt_reg + 1'b1;
                if (cmd.div_last && status.quo_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (status.quo_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_ERR:
            begin
                cmd.err_push = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // A new word only arrives when the digit stack has drained.
    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> status.emit_done)
        else $error("input accepted while digits are pending");

    // The division step counter only moves inside the division state.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (step_cnt_reg == '0))
        else $error("step counter nonzero outside division");

    // Leaving the division state happens only at the end of a digit.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (state_next != ST_DIV) |-> (step_cnt_reg == STEP_LAST))
        else $error("division left mid digit");

endmodule

>>> design/itbd_datapath.sv
// Datapath: magnitude register, radix divider, digit stack and output register.
module itbd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  itbd_pkg::itbd_cmd_t                 cmd,
    output itbd_pkg::itbd_status_t              status,
    input  logic [itbd_pkg::VALUE_W-1:0]        in_value,
    input  logic [itbd_pkg::BASE_W-1:0]         in_base,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [itbd_pkg::CHAR_W-1:0]         out_digit_char,
    output logic                                out_is_negative,
    output logic                                out_last,
    output logic                                out_base_error
);
    import itbd_pkg::*;

    logic [VALUE_W-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [BASE_W-1:0]  base_reg;
    logic               neg_reg;
    logic               err_reg;

    logic               push;
    logic [DIGIT_W-1:0] push_digit;
    logic               pop;
    logic [PTR_W-1:0]   rd_addr;
    logic [SP_W-1:0]    sp_reg;

    logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];
    logic [DIGIT_W-1:0] rd_digit_reg;
    logic               pre_valid_reg;
    logic               pre_last_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_neg_reg;
    logic               out_last_reg;
    logic               out_err_reg;
    logic               can_load;
    logic               load_out;

    // Base checks on the incoming word.
    assign status.bad_base = (in_base < BASE_MIN) || (in_base > BASE_MAX);
    assign status.pow2     = (in_base == BASE_2) || (in_base == BASE_4) ||
                             (in_base == BASE_8) || (in_base == BASE_16);

    // Magnitude load, eight restoring division steps, a power-of-two shift or an error push.
    always_comb
    begin
        logic [VALUE_W-1:0] w;
        logic [DIGIT_W-1:0] r;
        logic [DIGIT_W:0]   t;
        logic               qb;
        work_next  = work_reg;
        rem_next   = rem_reg;
        push       = 1'b0;
        push_digit = '0;
        w          = work_reg;
        r          = rem_reg;
        t          = '0;
        qb         = 1'b0;
        if (cmd.load)
        begin
            work_next = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
            rem_next  = '0;
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < DIV_BITS; i++)
            begin
                t  = {r, w[VALUE_W-1]};
                qb = (t >= base_reg);
                r  = qb ? DIGIT_W'(t - base_reg) : t[DIGIT_W-1:0];
                w  = {w[VALUE_W-2:0], qb};
            end
            work_next  = w;
            rem_next   = cmd.div_last ? '0 : r;
            push       = cmd.div_last;
            push_digit = r;
        end
        else if (cmd.shift_step)
        begin
            push = 1'b1;
            unique case (base_reg)
                BASE_2:
                begin
                    push_digit = DIGIT_W'(work_reg[0]);
                    work_next  = work_reg >> 1;
                end
                BASE_4:
                begin
                    push_digit = DIGIT_W'(work_reg[1:0]);
                    work_next  = work_reg >> 2;
                end
                BASE_8:
                begin
                    push_digit = DIGIT_W'(work_reg[2:0]);
                    work_next  = work_reg >> 3;
                end
                default:
                begin
                    push_digit = work_reg[3:0];
                    work_next  = work_reg >> 4;
                end
            endcase
        end
        else if (cmd.err_push)
        begin
            push = 1'b1;
        end
    end

    assign status.quo_zero = (work_next == '0);

    // Conversion registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (cmd.load)
        begin
            base_reg <= in_base;
            neg_reg  <= in_value[VALUE_W-1];
            err_reg  <= status.bad_base;
        end
    end

    // Emission handshake between the stack read register and the output register.
    assign can_load = !out_valid_reg || out_ready;
    assign load_out = pre_valid_reg && can_load;
    assign pop      = cmd.emit && (sp_reg != '0) && (!pre_valid_reg || can_load);
    assign rd_addr  = PTR_W'(sp_reg - 1'b1);
    assign status.emit_done = (sp_reg == '0) && !pre_valid_reg;

    // Digit stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[sp_reg[PTR_W-1:0]] <= push_digit;
        end
        if (pop)
        begin
            rd_digit_reg <= stack_mem[rd_addr];
            pre_last_reg <= (sp_reg == SP_W'(1));
        end
    end

    // Stack pointer and read valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            pre_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                sp_reg <= sp_reg + 1'b1;
            end
            else if (pop)
            begin
                sp_reg <= sp_reg - 1'b1;
            end
            if (pop)
            begin
                pre_valid_reg <= 1'b1;
            end
            else if (load_out)
            begin
                pre_valid_reg <= 1'b0;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_char_reg <= err_reg ? CHAR_NONE : digit_to_char(rd_digit_reg);
            out_neg_reg  <= neg_reg;
            out_last_reg <= pre_last_reg;
            out_err_reg  <= err_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_digit_char  = out_char_reg;
    assign out_is_negative = out_neg_reg;
    assign out_last        = out_last_reg;
    assign out_base_error  = out_err_reg;

    // The stack never overflows its depth.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (sp_reg != SP_W'(STACK_DEPTH)))
        else $error("digit stack overflow");

    // Pushing and popping never coincide.
    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("push and pop in the same cycle");

    // The read register is never overwritten before it moves to the output.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pre_valid_reg && !can_load) |-> !pop)
        else $error("pending digit overwritten");

endmodule
